// ===== rtl/core/sfwv_pkg.sv =====
// Package: shared types and constants for the SPI flash write/verify sequencer
`timescale 1ns / 1ps
package sfwv_pkg;
   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_REPLY = 2'd2;
   localparam logic [1:0] KIND_ERASE = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_ADDR  = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_ERASE = 3'd3;
   localparam logic [2:0] ST_WRITE_ERR = 3'd4;
   localparam logic [2:0] ST_CORRUPT   = 3'd5;
   localparam logic [2:0] ST_SPI_ERR   = 3'd6;

   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] CMD_PP    = 8'h02;
   localparam logic [7:0] CMD_WREN  = 8'h06;
   localparam logic [7:0] CMD_RDSR  = 8'h05;
   localparam logic [7:0] CMD_CE    = 8'h60;
   localparam logic [7:0] CMD_WRSR  = 8'h01;
   localparam logic [7:0] PROT_MASK = 8'h1C;
   localparam logic [7:0] WEL_ONLY  = 8'h02;
   localparam logic [7:0] BYTE_ERASED = 8'hFF;

   localparam logic [0:0] REG_FLASH_SIZE = 1'd0;
   localparam logic [0:0] REG_TIMEOUT    = 1'd1;

   localparam int MAX_RES = 8;
   localparam int CNT_W   = 4;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       expect_reply;
      logic       frame_end;
      logic       send_valid;
      logic       done_res;
      logic [2:0] status;
      logic [7:0] written_count;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] address;
      logic [7:0]  length;
      logic [7:0]  data_byte;
      logic        next_four_empty;
      logic [7:0]  reply_byte;
      logic        spi_error;
   } req_type;

   // one burst of results from one request, queued between front and back
   typedef struct packed {
      logic [MAX_RES-1:0][7:0] bytes;
      logic [MAX_RES-1:0]      exp;
      logic [MAX_RES-1:0]      fend;
      logic [CNT_W-1:0]        count;
      logic                    done;
      logic [2:0]              status;
      logic [7:0]              wcount;
   } burst_type;
endpackage

// ===== rtl/core/sfwv_if.sv =====
// Interfaces: request and result valid/ready channels
`timescale 1ns / 1ps
interface sfwv_req_if #(parameter int ADDR_BITS = 24);
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [ADDR_BITS-1:0] address;
   logic [7:0]           length;
   logic [7:0]           data_byte;
   logic                 next_four_empty;
   logic [7:0]           reply_byte;
   logic                 spi_error;
   modport source (output valid, kind, address, length, data_byte, next_four_empty,
                   reply_byte, spi_error, input ready);
   modport sink (input valid, kind, address, length, data_byte, next_four_empty,
                 reply_byte, spi_error, output ready);
endinterface

interface sfwv_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] spi_byte;
   logic       expect_reply;
   logic       frame_end;
   logic       send_valid;
   logic       done_res;
   logic [2:0] status;
   logic [7:0] written_count;
   logic       last;
   modport source (output valid, spi_byte, expect_reply, frame_end, send_valid, done_res,
                   status, written_count, last, input ready);
   modport sink (input valid, spi_byte, expect_reply, frame_end, send_valid, done_res,
                 status, written_count, last, output ready);
endinterface

// ===== rtl/core/spi_flash_write_verify_sequencer.sv =====
// Top level: SPI flash write/verify sequencer with APB register port
// A taken request's burst is first registered in the front, then pushed into the
// two-burst queue, from whose head its results are served.
// Throughput: one request per cycle unless a burst waits on a full queue; results
// leave one per cycle while the receiver is ready, up to seven per request.
// A two-burst queue between front and back lets each side stall alone.
// Synchronous active-high reset: idle phase, empty queue, registers at defaults.
`timescale 1ns / 1ps
module spi_flash_write_verify_sequencer #(
   parameter int ADDR_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   sfwv_req_if.sink    req,
   sfwv_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [24:0] fsize_ff;
   logic [15:0] tlim_ff;
   sfwv_pkg::req_type   rq;
   sfwv_pkg::burst_type bus;
   sfwv_pkg::rsp_type   rs;
   logic bvalid, bready;

   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         sfwv_pkg::REG_FLASH_SIZE: csr_prdata = {7'd0, fsize_ff};
         default:                  csr_prdata = {16'd0, tlim_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsize_ff <= 25'd2097152;
         tlim_ff  <= 16'd1000;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2] == sfwv_pkg::REG_FLASH_SIZE) fsize_ff <= csr_pwdata[24:0];
         else tlim_ff <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      rq = '0;
      rq.kind            = req.kind;
      rq.length          = req.length;
      rq.data_byte       = req.data_byte;
      rq.next_four_empty = req.next_four_empty;
      rq.reply_byte      = req.reply_byte;
      rq.spi_error       = req.spi_error;
   end

   sfwv_front #(.ADDR_BITS(ADDR_BITS)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_req(rq), .in_addr(req.address),
      .flash_size(fsize_ff), .timeout_limit(tlim_ff),
      .burst_valid(bvalid), .burst_ready(bready), .burst(bus)
   );

   sfwv_back u_back (
      .clock, .reset,
      .burst_valid(bvalid), .burst_ready(bready), .burst(bus),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(rs)
   );

   assign rsp.spi_byte      = rs.spi_byte;
   assign rsp.expect_reply  = rs.expect_reply;
   assign rsp.frame_end     = rs.frame_end;
   assign rsp.send_valid    = rs.send_valid;
   assign rsp.done_res      = rs.done_res;
   assign rsp.status        = rs.status;
   assign rsp.written_count = rs.written_count;
   assign rsp.last          = rs.last;
endmodule

// ===== rtl/core/sfwv_front.sv =====
// Front: decodes each request against the sequencer state and builds the result burst, if any
`timescale 1ns / 1ps
module sfwv_front #(
   parameter int ADDR_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  sfwv_pkg::req_type        in_req,
   input  logic [ADDR_BITS-1:0]     in_addr,
   input  logic [24:0]              flash_size,
   input  logic [15:0]              timeout_limit,
   output logic                     burst_valid,
   input  logic                     burst_ready,
   output sfwv_pkg::burst_type      burst
);
   localparam logic [2:0] PH_IDLE = 3'd0, PH_WAIT_DATA = 3'd1, PH_PRE_READ = 3'd2,
                          PH_EW_FIRST = 3'd3, PH_EW_PROT = 3'd4, PH_EW_WEL = 3'd5,
                          PH_BUSY = 3'd6, PH_VERIFY = 3'd7;

   logic [2:0]           phase_ff, phase_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [7:0]           pend_ff, pend_in, remain_ff, remain_in, vcount_ff, vcount_in;
   logic [15:0]          poll_ff, poll_in;
   logic                 erase_ff, erase_in;
   logic                 bval_ff;
   sfwv_pkg::burst_type  b_ff, b_in;

   logic [15:0] lim;
   logic [15:0] pdec;
   logic [7:0]  rep;
   logic        take;
   logic [ADDR_BITS:0] sum;

   function automatic sfwv_pkg::burst_type add_byte(input sfwv_pkg::burst_type b,
         input logic [7:0] v, input logic e, input logic f);
      sfwv_pkg::burst_type r;
      r = b;
      r.bytes[b.count[2:0]] = v;
      r.exp[b.count[2:0]]   = e;
      r.fend[b.count[2:0]]  = f;
      r.count = b.count + 4'd1;
      return r;
   endfunction

   function automatic sfwv_pkg::burst_type add_addr(input sfwv_pkg::burst_type b,
         input logic [ADDR_BITS-1:0] a);
      sfwv_pkg::burst_type r;
      logic [31:0] w;
      w = 32'(a);
      r = add_byte(b, w[23:16], 1'b0, 1'b0);
      r = add_byte(r, w[15:8], 1'b0, 1'b0);
      r = add_byte(r, w[7:0], 1'b0, 1'b0);
      return r;
   endfunction

   function automatic sfwv_pkg::burst_type add_rdsr(input sfwv_pkg::burst_type b);
      sfwv_pkg::burst_type r;
      r = add_byte(b, sfwv_pkg::CMD_RDSR, 1'b0, 1'b0);
      r = add_byte(r, 8'h00, 1'b1, 1'b1);
      return r;
   endfunction

   function automatic sfwv_pkg::burst_type add_read(input sfwv_pkg::burst_type b,
         input logic [ADDR_BITS-1:0] a);
      sfwv_pkg::burst_type r;
      r = add_byte(b, sfwv_pkg::CMD_READ, 1'b0, 1'b0);
      r = add_addr(r, a);
      r = add_byte(r, 8'h00, 1'b1, 1'b1);
      return r;
   endfunction

   assign lim = (timeout_limit == 16'd0) ? 16'd1 : timeout_limit;
   assign in_ready = !bval_ff || burst_ready;
   assign take = in_valid && in_ready;
   assign burst_valid = bval_ff;
   assign burst = b_ff;
   assign rep = in_req.reply_byte;
   assign sum = {1'b0, in_addr} + {{(ADDR_BITS-7){1'b0}}, in_req.length};

   always_comb begin
      phase_in  = phase_ff;
      addr_in   = addr_ff;
      pend_in   = pend_ff;
      remain_in = remain_ff;
      vcount_in = vcount_ff;
      poll_in   = poll_ff;
      erase_in  = erase_ff;
      b_in      = '0;
      pdec      = (poll_ff > 16'd0) ? poll_ff - 16'd1 : 16'd0;

      // emit/finish helpers written out as sequential appends
      unique case (phase_ff)
         PH_IDLE: begin
            if (in_req.kind == sfwv_pkg::KIND_BEGIN) begin
               vcount_in = 8'd0;
               erase_in  = 1'b0;
               if ({{(33-ADDR_BITS-1){1'b0}}, sum} >= {8'd0, flash_size}) begin
                  b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_BAD_ADDR; phase_in = PH_IDLE;
               end else if (in_req.length == 8'd0) begin
                  b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_OK; phase_in = PH_IDLE;
               end else begin
                  addr_in = in_addr; remain_in = in_req.length; phase_in = PH_WAIT_DATA;
               end
            end else if (in_req.kind == sfwv_pkg::KIND_ERASE) begin
               vcount_in = 8'd0; erase_in = 1'b1; poll_in = lim;
               b_in = add_rdsr(b_in); phase_in = PH_EW_FIRST;
            end
         end
         PH_WAIT_DATA: begin
            if (in_req.kind == sfwv_pkg::KIND_DATA) begin
               pend_in = in_req.data_byte;
               if (in_req.data_byte == sfwv_pkg::BYTE_ERASED && in_req.next_four_empty) begin
                  b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_EMPTY; phase_in = PH_IDLE;
               end else begin
                  b_in = add_read(b_in, addr_ff); phase_in = PH_PRE_READ;
               end
            end
         end
         default: begin
            if (in_req.kind == sfwv_pkg::KIND_REPLY) begin
               if (phase_ff == PH_PRE_READ) begin
                  if (in_req.spi_error) begin
                     b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_WRITE_ERR; phase_in = PH_IDLE;
                  end else if (rep != sfwv_pkg::BYTE_ERASED) begin
                     b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_NOT_ERASE; phase_in = PH_IDLE;
                  end else begin
                     poll_in = lim; b_in = add_rdsr(b_in); phase_in = PH_EW_FIRST;
                  end
               end else if (phase_ff == PH_BUSY) begin
                  if (in_req.spi_error) begin
                     b_in.done = 1'b1; phase_in = PH_IDLE;
                     b_in.status = erase_ff ? sfwv_pkg::ST_SPI_ERR : sfwv_pkg::ST_WRITE_ERR;
                  end else begin
                     poll_in = pdec;
                     if (rep[0] && pdec > 16'd0) begin
                        b_in = add_rdsr(b_in); phase_in = PH_BUSY;
                     end else if (erase_ff) begin
                        b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_OK; phase_in = PH_IDLE;
                     end else begin
                        b_in = add_read(b_in, addr_ff); phase_in = PH_VERIFY;
                     end
                  end
               end else if (phase_ff == PH_VERIFY) begin
                  if (in_req.spi_error) begin
                     b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_WRITE_ERR; phase_in = PH_IDLE;
                  end else if (rep != pend_ff) begin
                     b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_CORRUPT; phase_in = PH_IDLE;
                  end else begin
                     vcount_in = vcount_ff + 8'd1;
                     addr_in   = addr_ff + {{(ADDR_BITS-1){1'b0}}, 1'b1};
                     remain_in = remain_ff - 8'd1;
                     if (remain_in == 8'd0) begin
                        b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_OK; phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_WAIT_DATA;
                     end
                  end
               end else begin
                  // enable loop: protect clear, then write-enable latch
                  if (in_req.spi_error) begin
                     b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_SPI_ERR; phase_in = PH_IDLE;
                  end else begin
                     if (phase_ff != PH_EW_FIRST) poll_in = pdec;
                     if (phase_ff == PH_EW_PROT || phase_ff == PH_EW_FIRST) begin
                        if ((rep & sfwv_pkg::PROT_MASK) != 8'd0 && poll_in > 16'd0) begin
                           b_in = add_byte(b_in, sfwv_pkg::CMD_WREN, 1'b0, 1'b1);
                           b_in = add_byte(b_in, sfwv_pkg::CMD_WRSR, 1'b0, 1'b0);
                           b_in = add_byte(b_in, 8'h00, 1'b0, 1'b1);
                           b_in = add_rdsr(b_in); phase_in = PH_EW_PROT;
                        end else if (poll_in == 16'd0) begin
                           b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_WRITE_ERR;
                           phase_in = PH_IDLE;
                        end else begin
                           poll_in = lim;
                           phase_in = PH_EW_WEL; // falls into the latch check below
                        end
                     end
                     if (phase_in == PH_EW_WEL && !b_in.done && b_in.count == '0) begin
                        if (rep != sfwv_pkg::WEL_ONLY && poll_in > 16'd0) begin
                           b_in = add_byte(b_in, sfwv_pkg::CMD_WREN, 1'b0, 1'b1);
                           b_in = add_rdsr(b_in);
                        end else if (poll_in == 16'd0) begin
                           b_in.done = 1'b1; b_in.status = sfwv_pkg::ST_WRITE_ERR;
                           phase_in = PH_IDLE;
                        end else begin
                           if (erase_ff) begin
                              b_in = add_byte(b_in, sfwv_pkg::CMD_CE, 1'b0, 1'b1);
                           end else begin
                              b_in = add_byte(b_in, sfwv_pkg::CMD_PP, 1'b0, 1'b0);
                              b_in = add_addr(b_in, addr_ff);
                              b_in = add_byte(b_in, pend_ff, 1'b0, 1'b1);
                           end
                           poll_in = lim; b_in = add_rdsr(b_in); phase_in = PH_BUSY;
                        end
                     end
                  end
               end
            end
         end
      endcase
      b_in.wcount = vcount_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         addr_ff   <= '0;
         pend_ff   <= '0;
         remain_ff <= '0;
         vcount_ff <= '0;
         poll_ff   <= '0;
         erase_ff  <= 1'b0;
         bval_ff   <= 1'b0;
      end else begin
         if (take) begin
            phase_ff  <= phase_in;
            addr_ff   <= addr_in;
            pend_ff   <= pend_in;
            remain_ff <= remain_in;
            vcount_ff <= vcount_in;
            poll_ff   <= poll_in;
            erase_ff  <= erase_in;
         end
         if (take) begin
            bval_ff <= (b_in.count != '0) || b_in.done;
         end else if (burst_ready) begin
            bval_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         b_ff <= b_in;
      end
   end
endmodule

// ===== rtl/core/sfwv_back.sv =====
// Back: two-entry burst queue and serialiser onto the result channel
`timescale 1ns / 1ps
module sfwv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                burst_valid,
   output logic                burst_ready,
   input  sfwv_pkg::burst_type burst,
   output logic                out_valid,
   input  logic                out_ready,
   output sfwv_pkg::rsp_type   out_rsp
);
   sfwv_pkg::burst_type q_ff [2];
   logic [1:0]  fill_ff;
   logic        rd_ff, wr_ff;
   logic [sfwv_pkg::CNT_W-1:0] pos_ff;
   sfwv_pkg::burst_type h;
   logic [sfwv_pkg::CNT_W-1:0] total;
   logic is_last, pop, push;

   assign h = q_ff[rd_ff];
   assign total = h.count + (h.done ? 4'd1 : 4'd0);
   assign is_last = (pos_ff + 4'd1) == total;
   assign out_valid = fill_ff != 2'd0;
   assign pop = out_valid && out_ready && is_last;
   assign burst_ready = fill_ff != 2'd2;
   assign push = burst_valid && burst_ready;

   always_comb begin
      out_rsp = '0;
      out_rsp.written_count = h.wcount;
      out_rsp.last = is_last;
      if (pos_ff < h.count) begin
         out_rsp.spi_byte     = h.bytes[pos_ff[2:0]];
         out_rsp.expect_reply = h.exp[pos_ff[2:0]];
         out_rsp.frame_end    = h.fend[pos_ff[2:0]];
         out_rsp.send_valid   = 1'b1;
      end else begin
         out_rsp.done_res = 1'b1;
         out_rsp.status   = h.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         rd_ff   <= 1'b0;
         wr_ff   <= 1'b0;
         pos_ff  <= '0;
      end else begin
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
         if (push) wr_ff <= !wr_ff;
         if (pop) begin
            rd_ff  <= !rd_ff;
            pos_ff <= '0;
         end else if (out_valid && out_ready) begin
            pos_ff <= pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= burst;
   end
endmodule

// ===== rtl/core/sfwv_checker.sv =====
// Checker: port-level assertions for the sequencer, bound to the top level
`timescale 1ns / 1ps
module sfwv_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       send_valid,
   input logic       done_res,
   input logic       expect_reply,
   input logic       frame_end,
   input logic       last,
   input logic [7:0] spi_byte,
   input logic [2:0] status
);
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (send_valid ^ done_res)) else $error("slot and done both or neither");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> last && spi_byte == 8'd0) else $error("done not last");
   a_reply_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && expect_reply |-> frame_end && spi_byte == 8'd0)
      else $error("reply slot must close frame");
   a_slot_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && send_valid |-> status == 3'd0) else $error("status in byte slot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule

bind spi_flash_write_verify_sequencer sfwv_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .send_valid(rsp.send_valid), .done_res(rsp.done_res), .expect_reply(rsp.expect_reply),
   .frame_end(rsp.frame_end), .last(rsp.last), .spi_byte(rsp.spi_byte), .status(rsp.status)
);

// ===== dv/testbench.sv =====
// Testbench for the SPI flash write/verify sequencer: random and directed requests, checked
// against a behavioural predictor.
`timescale 1ns / 1ps
module testbench;
   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_WAIT_DATA, SEQ_PRE_READ, SEQ_EN_FIRST, SEQ_EN_PROT, SEQ_EN_WEL,
      SEQ_BUSY, SEQ_VERIFY
   } seq_phase_type;

   typedef struct {
      seq_phase_type ph;
      logic [23:0] cur_addr;
      logic [7:0]  pend;
      logic [7:0]  remain;
      logic [15:0] polls;
      logic [7:0]  verified;
      logic        erasing;
      logic [24:0] fsize;
      logic [15:0] tlimit;
   } seq_state_type;

   localparam logic [2:0] ADDR_FLASH_SIZE = 3'd0;
   localparam logic [2:0] ADDR_TIMEOUT    = 3'd4;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   sfwv_req_if #(.ADDR_BITS(24)) req_bus ();
   sfwv_rsp_if rsp_bus ();

   spi_flash_write_verify_sequencer #(.ADDR_BITS(24)) dut (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   seq_state_type        model_st, plan_st;
   sfwv_pkg::req_type    pending_reqs[$];
   sfwv_pkg::rsp_type    expected_rsps[$];
   int         mismatches = 0;
   int         cycles = 0;
   bit         quiet_mode = 0;
   bit         hold_rsp = 0;
   bit         stall_now = 0;

   function automatic void seq_init(ref seq_state_type s);
      s.ph = SEQ_IDLE; s.cur_addr = '0; s.pend = '0; s.remain = '0; s.polls = '0;
      s.verified = '0; s.erasing = 1'b0; s.fsize = 25'd2097152; s.tlimit = 16'd1000;
   endfunction

   function automatic logic [15:0] poll_budget(ref seq_state_type s);
      return (s.tlimit == 16'd0) ? 16'd1 : s.tlimit;
   endfunction

   function automatic void put_rsp(ref seq_state_type s, ref sfwv_pkg::rsp_type q[$],
                                   input logic [7:0] b,
                                   input logic e, input logic f, input logic sv,
                                   input logic dn, input logic [2:0] st);
      sfwv_pkg::rsp_type r;
      r.spi_byte = b; r.expect_reply = e; r.frame_end = f; r.send_valid = sv;
      r.done_res = dn; r.status = st; r.written_count = s.verified; r.last = 1'b0;
      q.push_back(r);
   endfunction

   function automatic void send_byte(ref seq_state_type s, ref sfwv_pkg::rsp_type q[$],
                                     input logic [7:0] b, input logic e, input logic f);
      put_rsp(s, q, b, e, f, 1'b1, 1'b0, sfwv_pkg::ST_OK);
   endfunction

   function automatic void end_op(ref seq_state_type s, ref sfwv_pkg::rsp_type q[$],
                                  input logic [2:0] st);
      put_rsp(s, q, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, st);
      s.ph = SEQ_IDLE;
   endfunction

   function automatic void send_addr(ref seq_state_type s, ref sfwv_pkg::rsp_type q[$]);
      send_byte(s, q, s.cur_addr[23:16], 1'b0, 1'b0);
      send_byte(s, q, s.cur_addr[15:8], 1'b0, 1'b0);
      send_byte(s, q, s.cur_addr[7:0], 1'b0, 1'b0);
   endfunction

   function automatic void read_status(ref seq_state_type s, ref sfwv_pkg::rsp_type q[$],
                                       input seq_phase_type nxt);
      send_byte(s, q, sfwv_pkg::CMD_RDSR, 1'b0, 1'b0);
      send_byte(s, q, 8'h00, 1'b1, 1'b1);
      s.ph = nxt;
   endfunction

   function automatic void read_back(ref seq_state_type s, ref sfwv_pkg::rsp_type q[$],
                                     input seq_phase_type nxt);
      send_byte(s, q, sfwv_pkg::CMD_READ, 1'b0, 1'b0);
      send_addr(s, q);
      send_byte(s, q, 8'h00, 1'b1, 1'b1);
      s.ph = nxt;
   endfunction

   function automatic void start_program(ref seq_state_type s, ref sfwv_pkg::rsp_type q[$]);
      if (s.erasing) begin
         send_byte(s, q, sfwv_pkg::CMD_CE, 1'b0, 1'b1);
      end else begin
         send_byte(s, q, sfwv_pkg::CMD_PP, 1'b0, 1'b0);
         send_addr(s, q);
         send_byte(s, q, s.pend, 1'b0, 1'b1);
      end
      s.polls = poll_budget(s);
      read_status(s, q, SEQ_BUSY);
   endfunction

   function automatic void wel_check(ref seq_state_type s, ref sfwv_pkg::rsp_type q[$],
                                     input logic [7:0] st);
      if (st != sfwv_pkg::WEL_ONLY && s.polls > 0) begin
         send_byte(s, q, sfwv_pkg::CMD_WREN, 1'b0, 1'b1);
         read_status(s, q, SEQ_EN_WEL);
      end else if (s.polls == 0) begin
         end_op(s, q, sfwv_pkg::ST_WRITE_ERR);
      end else begin
         start_program(s, q);
      end
   endfunction

   function automatic void prot_check(ref seq_state_type s, ref sfwv_pkg::rsp_type q[$],
                                      input logic [7:0] st);
      if ((st & sfwv_pkg::PROT_MASK) != 0 && s.polls > 0) begin
         send_byte(s, q, sfwv_pkg::CMD_WREN, 1'b0, 1'b1);
         send_byte(s, q, sfwv_pkg::CMD_WRSR, 1'b0, 1'b0);
         send_byte(s, q, 8'h00, 1'b0, 1'b1);
         read_status(s, q, SEQ_EN_PROT);
      end else if (s.polls == 0) begin
         end_op(s, q, sfwv_pkg::ST_WRITE_ERR);
      end else begin
         s.polls = poll_budget(s);
         wel_check(s, q, st);
      end
   endfunction

   // one request through the sequencer; appends the results it causes
   function automatic void flash_step(ref seq_state_type s, input sfwv_pkg::req_type r,
                                      ref sfwv_pkg::rsp_type q[$]);
      int n0;
      n0 = q.size();
      case (s.ph)
         SEQ_IDLE: begin
            if (r.kind == sfwv_pkg::KIND_BEGIN) begin
               s.verified = '0; s.erasing = 1'b0;
               if ({1'b0, r.address} + r.length >= {1'b0, s.fsize})
                  end_op(s, q, sfwv_pkg::ST_BAD_ADDR);
               else if (r.length == 0)
                  end_op(s, q, sfwv_pkg::ST_OK);
               else begin
                  s.cur_addr = r.address; s.remain = r.length; s.ph = SEQ_WAIT_DATA;
               end
            end else if (r.kind == sfwv_pkg::KIND_ERASE) begin
               s.verified = '0; s.erasing = 1'b1; s.polls = poll_budget(s);
               read_status(s, q, SEQ_EN_FIRST);
            end
         end
         SEQ_WAIT_DATA: begin
            if (r.kind == sfwv_pkg::KIND_DATA) begin
               s.pend = r.data_byte;
               if (r.data_byte == sfwv_pkg::BYTE_ERASED && r.next_four_empty)
                  end_op(s, q, sfwv_pkg::ST_EMPTY);
               else read_back(s, q, SEQ_PRE_READ);
            end
         end
         default: begin
            if (r.kind == sfwv_pkg::KIND_REPLY) begin
               case (s.ph)
                  SEQ_PRE_READ: begin
                     if (r.spi_error) end_op(s, q, sfwv_pkg::ST_WRITE_ERR);
                     else if (r.reply_byte != sfwv_pkg::BYTE_ERASED)
                        end_op(s, q, sfwv_pkg::ST_NOT_ERASE);
                     else begin
                        s.polls = poll_budget(s);
                        read_status(s, q, SEQ_EN_FIRST);
                     end
                  end
                  SEQ_EN_FIRST, SEQ_EN_PROT, SEQ_EN_WEL: begin
                     if (r.spi_error) end_op(s, q, sfwv_pkg::ST_SPI_ERR);
                     else begin
                        if (s.ph != SEQ_EN_FIRST && s.polls > 0) s.polls--;
                        if (s.ph == SEQ_EN_WEL) wel_check(s, q, r.reply_byte);
                        else prot_check(s, q, r.reply_byte);
                     end
                  end
                  SEQ_BUSY: begin
                     if (r.spi_error)
                        end_op(s, q, s.erasing ? sfwv_pkg::ST_SPI_ERR : sfwv_pkg::ST_WRITE_ERR);
                     else begin
                        if (s.polls > 0) s.polls--;
                        if (r.reply_byte[0] && s.polls > 0) read_status(s, q, SEQ_BUSY);
                        else if (s.erasing) end_op(s, q, sfwv_pkg::ST_OK);
                        else read_back(s, q, SEQ_VERIFY);
                     end
                  end
                  default: begin
                     if (r.spi_error) end_op(s, q, sfwv_pkg::ST_WRITE_ERR);
                     else if (r.reply_byte != s.pend) end_op(s, q, sfwv_pkg::ST_CORRUPT);
                     else begin
                        s.verified++; s.cur_addr++; s.remain--;
                        if (s.remain == 0) end_op(s, q, sfwv_pkg::ST_OK);
                        else s.ph = SEQ_WAIT_DATA;
                     end
                  end
               endcase
            end
         end
      endcase
      if (q.size() > n0) q[q.size()-1].last = 1'b1;
   endfunction

   // queue a request, tracking the sequencer state the plan will reach
   task automatic queue_req(input sfwv_pkg::req_type r);
      sfwv_pkg::rsp_type scratch[$];
      flash_step(plan_st, r, scratch);
      pending_reqs.push_back(r);
   endtask

   function automatic sfwv_pkg::req_type noise_req();
      sfwv_pkg::req_type r;
      r.kind = 2'($urandom); r.address = 24'($urandom); r.length = 8'($urandom);
      r.data_byte = 8'($urandom); r.next_four_empty = 1'($urandom);
      r.reply_byte = 8'($urandom); r.spi_error = 1'($urandom);
      return r;
   endfunction

   // mostly well-formed traffic for the planned state; clean forces the happy path
   function automatic sfwv_pkg::req_type plan_req(input bit clean);
      sfwv_pkg::req_type r;
      int p;
      r = noise_req();
      p = $urandom_range(0, 99);
      r.spi_error = clean ? 1'b0 : ($urandom_range(0, 99) < 4);
      case (plan_st.ph)
         SEQ_IDLE: begin
            if (p < 62) begin
               r.kind = sfwv_pkg::KIND_BEGIN;
               p = $urandom_range(0, 99);
               r.length = (p < 8) ? 8'd0 : (p < 90) ? 8'($urandom_range(1, 3))
                        : 8'($urandom_range(4, 12));
               if ($urandom_range(0, 9) < 8 && plan_st.fsize > r.length + 1)
                  r.address = 24'($urandom_range(0, plan_st.fsize - r.length - 1));
            end else if (p < 80) begin
               r.kind = sfwv_pkg::KIND_ERASE;
            end else if (p < 90) begin
               r.kind = ($urandom_range(0, 1)) ? sfwv_pkg::KIND_DATA : sfwv_pkg::KIND_REPLY;
            end
         end
         SEQ_WAIT_DATA: begin
            if (clean || p < 92) r.kind = sfwv_pkg::KIND_DATA;
            if (clean) r.next_four_empty = 1'b0;
            else if ($urandom_range(0, 9) == 0) r.data_byte = sfwv_pkg::BYTE_ERASED;
         end
         default: begin
            if (clean || p < 94) r.kind = sfwv_pkg::KIND_REPLY;
            p = $urandom_range(0, 99);
            if (clean || p < 75) begin
               case (plan_st.ph)
                  SEQ_PRE_READ: r.reply_byte = sfwv_pkg::BYTE_ERASED;
                  SEQ_EN_FIRST, SEQ_EN_PROT, SEQ_EN_WEL: r.reply_byte = sfwv_pkg::WEL_ONLY;
                  SEQ_BUSY: r.reply_byte[0] = 1'b0;
                  default: r.reply_byte = plan_st.pend;
               endcase
            end else if (p < 90 && plan_st.ph == SEQ_BUSY) begin
               r.reply_byte[0] = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   function automatic sfwv_pkg::req_type make_req(input logic [1:0] k, input logic [23:0] a,
                                        input logic [7:0] l, input logic [7:0] d,
                                        input logic e, input logic [7:0] rb, input logic er);
      sfwv_pkg::req_type r;
      r.kind = k; r.address = a; r.length = l; r.data_byte = d;
      r.next_four_empty = e; r.reply_byte = rb; r.spi_error = er;
      return r;
   endfunction

   task automatic csr_write(input logic [2:0] a, input logic [31:0] v);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= a; csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (a == ADDR_FLASH_SIZE) begin
         model_st.fsize = v[24:0]; plan_st.fsize = v[24:0];
      end else begin
         model_st.tlimit = v[15:0]; plan_st.tlimit = v[15:0];
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_run(input int n);
      repeat (n) queue_req(plan_req(1'b0));
      // bring the sequence back to idle so the registers can change
      while (plan_st.ph != SEQ_IDLE) queue_req(plan_req(1'b1));
   endtask

   // request driver
   logic [4:0] send_gap = '0;
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 5'd0) begin
            send_gap <= send_gap - 5'd1;
            req_bus.valid <= 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            send_gap <= 5'($urandom_range(0, 17));
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            sfwv_pkg::req_type r;
            r = pending_reqs.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.kind <= r.kind; req_bus.address <= r.address;
            req_bus.length <= r.length; req_bus.data_byte <= r.data_byte;
            req_bus.next_four_empty <= r.next_four_empty;
            req_bus.reply_byte <= r.reply_byte; req_bus.spi_error <= r.spi_error;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   logic [4:0] stall_left = '0;
   always @(negedge clock) begin
      if (reset || quiet_mode) begin
         stall_left <= '0;
         rsp_bus.ready <= !hold_rsp && !reset;
      end else if (stall_left != 5'd0) begin
         stall_left <= stall_left - 5'd1;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= 5'($urandom_range(0, 17));
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !hold_rsp;
      end
   end

   // predictor on accepted requests, checker on accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sfwv_pkg::req_type r;
            r = make_req(req_bus.kind, req_bus.address, req_bus.length, req_bus.data_byte,
                         req_bus.next_four_empty, req_bus.reply_byte, req_bus.spi_error);
            flash_step(model_st, r, expected_rsps);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sfwv_pkg::rsp_type got, want;
            got.spi_byte = rsp_bus.spi_byte; got.expect_reply = rsp_bus.expect_reply;
            got.frame_end = rsp_bus.frame_end; got.send_valid = rsp_bus.send_valid;
            got.done_res = rsp_bus.done_res; got.status = rsp_bus.status;
            got.written_count = rsp_bus.written_count; got.last = rsp_bus.last;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got.spi_byte !== want.spi_byte || got.expect_reply !== want.expect_reply ||
                   got.frame_end !== want.frame_end || got.send_valid !== want.send_valid ||
                   got.done_res !== want.done_res || got.status !== want.status ||
                   got.written_count !== want.written_count || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp byte=%h er=%b fe=%b sv=%b dn=%b st=%0d wc=%0d l=%b",
                              want.spi_byte, want.expect_reply, want.frame_end,
                              want.send_valid, want.done_res, want.status,
                              want.written_count, want.last,
                              "\n          got byte=%h er=%b fe=%b sv=%b dn=%b st=%0d wc=%0d l=%b",
                              got.spi_byte, got.expect_reply, got.frame_end, got.send_valid,
                              got.done_res, got.status, got.written_count, got.last);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0; req_bus.kind = '0; req_bus.address = '0; req_bus.length = '0;
      req_bus.data_byte = '0; req_bus.next_four_empty = 1'b0; req_bus.reply_byte = '0;
      req_bus.spi_error = 1'b0; rsp_bus.ready = 1'b0;
      seq_init(model_st);
      seq_init(plan_st);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: range checks, empty request, empty run, full write, erase, failures
      queue_req(make_req(sfwv_pkg::KIND_BEGIN, 24'hFFFFFF, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_BEGIN, 24'h1FFFFF, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_BEGIN, 24'h000100, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_DATA, 24'h0, 8'h0, 8'h55, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_BEGIN, 24'h000000, 8'h02, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'hFF, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_DATA, 24'h0, 8'h0, 8'hFF, 1'b1, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_BEGIN, 24'h0FFFFF, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_DATA, 24'h0, 8'h0, 8'hA5, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'hFF, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'h1C, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'h02, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'h01, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'hA5, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_ERASE, 24'h0, 8'h0, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'h00, 1'b1));
      queue_req(make_req(sfwv_pkg::KIND_BEGIN, 24'h000010, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_DATA, 24'h0, 8'h0, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'h7E, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_BEGIN, 24'h000010, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_DATA, 24'h0, 8'h0, 8'h00, 1'b0, 8'h00, 1'b0));
      queue_req(make_req(sfwv_pkg::KIND_REPLY, 24'h0, 8'h0, 8'h00, 1'b0, 8'hFF, 1'b1));
      drain();

      // tight poll budget so enable timeouts and busy give-ups occur
      csr_write(ADDR_TIMEOUT, 32'd1);
      csr_write(ADDR_FLASH_SIZE, 32'd16777216);
      random_run(70);
      drain();
      csr_write(ADDR_TIMEOUT, 32'd0);
      csr_write(ADDR_FLASH_SIZE, 32'd1);
      random_run(25);
      drain();
      csr_write(ADDR_TIMEOUT, 32'd3);
      csr_write(ADDR_FLASH_SIZE, 32'd4096);
      random_run(80);
      // receiver holds off while requests keep coming
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      drain();
      csr_write(ADDR_TIMEOUT, 32'd65535);
      csr_write(ADDR_FLASH_SIZE, 32'd2097152);
      random_run(100);
      drain();
      quiet_mode = 1'b1;
      csr_write(ADDR_TIMEOUT, 32'd2);
      random_run(60);
      drain();

      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
